// ===== hw/rtl/srb_pkg.sv =====
// Shared types and constants for the sprite row blitter.
package srb_pkg;

	localparam int SPRITE_SIZE = 16;
	localparam int COL_W       = 4;
	localparam int CODE_W      = 6;
	localparam int CODE_SPAN   = 64;
	localparam int PEN_DEPTH   = 256;
	localparam int PEN_W       = 8;
	localparam int LOAD_ADDR_W = 14;
	localparam int S_DATA_W    = 56;
	localparam int S_USER_W    = 2;
	localparam int M_DATA_W    = 24;

	localparam logic [7:0] Y_ORIGIN = 8'd224;
	localparam logic [7:0] Y_HIDDEN = 8'd240;

	typedef enum logic [1:0] {
		REQ_LOAD_PIX = 2'd0,
		REQ_LOAD_PEN = 2'd1,
		REQ_DRAW     = 2'd2
	} req_t;

	typedef struct packed {
		logic [1:0]             pad;
		logic [3:0]             row;
		logic [7:0]             pos_y_byte;
		logic [7:0]             attr_byte;
		logic [7:0]             code_byte;
		logic [7:0]             pos_x_byte;
		logic [3:0]             load_data;
		logic [LOAD_ADDR_W-1:0] load_addr;
	} s_word_t;

	typedef struct packed {
		logic [7:0] pen;
		logic [7:0] pix_y;
		logic [7:0] pix_x;
	} m_word_t;

endpackage

// ===== hw/rtl/srb_ram.sv =====
// Generic simple dual-port RAM with a registered, read-first read port.
module srb_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/sprite_row_blitter_core.sv =====
// Sprite row blitter: pixel and transparency stores plus the row drawing pipeline.
//
// Load words (pixel or transparency bit) are taken when the column sequencer is idle or on its
// last column and the output does not stall. A draw word for an on-screen row occupies the
// sequencer for its 16 columns, one read of the pixel memory per column, and the next word is
// taken in the cycle of its last column. A draw word whose row is hidden or off screen starts
// no columns and writes nothing. A pixel passes the s1 and s2 stages, then is held until the
// next opaque visible pixel or the row end tells whether it is the last of the row. Both stores
// are undefined after reset and need no clearing pass, so words are taken from the first cycle.
module sprite_row_blitter_core #(
	parameter int SPRITE_COUNT  = 64,
	parameter int SCREEN_WIDTH  = 256,
	parameter int SCREEN_HEIGHT = 224
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// load_addr, load_data, pos_x_byte, code_byte, attr_byte, pos_y_byte, row, zero pad
	input  logic [srb_pkg::S_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic [srb_pkg::S_USER_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pix_x, pix_y, pen
	output logic [srb_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                           m_tlast
);

	import srb_pkg::*;

	localparam int PIX_DEPTH = SPRITE_COUNT * SPRITE_SIZE * SPRITE_SIZE;
	localparam int PIX_AW    = $clog2(PIX_DEPTH);

	s_word_t in_w;
	req_t    req;
	m_word_t out_w;

	logic [CODE_W-1:0] code_mod_lut [CODE_SPAN];

	for (genvar i = 0; i < CODE_SPAN; i++) begin : g_code_lut
		assign code_mod_lut[i] = CODE_W'(i % SPRITE_COUNT);
	end

	// Column sequencer state.
	logic              busy_q;
	logic [COL_W-1:0]  col_q;
	logic [7:0]        xb_q;
	logic [7:0]        sy_q;
	logic [3:0]        color_q;
	logic [CODE_W-1:0] code_q;
	logic [3:0]        row_q;
	logic              flipx_q;
	logic              flipy_q;

	// Pipeline stages.
	logic              col_v_s1;
	logic              vis_s1;
	logic              end_s1;
	logic [7:0]        sx_s1;
	logic [7:0]        sy_s1;
	logic [3:0]        color_s1;
	logic              pwe_s1;
	logic [7:0]        paddr_s1;
	logic              pdata_s1;

	logic              col_v_s2;
	logic              vis_s2;
	logic              end_s2;
	logic [7:0]        sx_s2;
	logic [7:0]        sy_s2;
	logic [PEN_W-1:0]  pen_s2;

	logic              pend_v_q;
	logic              pend_final_q;
	logic [7:0]        pend_x_q;
	logic [7:0]        pend_y_q;
	logic [PEN_W-1:0]  pend_pen_q;

	logic              out_v_q;
	logic              out_last_q;
	logic [7:0]        out_x_q;
	logic [7:0]        out_y_q;
	logic [PEN_W-1:0]  out_pen_q;

	logic              col_last;
	logic              advance;
	logic              accept;
	logic              start;
	logic signed [9:0] sy_full;
	logic              row_on;
	logic [8:0]        sx_full;
	logic [13:0]       pix_idx;
	logic [3:0]        pix_rd;
	logic              pen_transp;
	logic              pix_we;
	logic              slot_emit;
	logic              slot_end;
	logic              move;

	assign in_w = s_word_t'(s_tdata);
	assign req  = req_t'(s_tuser);

	assign col_last = (col_q == COL_W'(SPRITE_SIZE - 1));

	assign slot_emit = col_v_s2 && vis_s2 && !pen_transp;
	assign slot_end  = col_v_s2 && end_s2;
	assign move      = pend_v_q && (pend_final_q || slot_emit || slot_end);
	assign advance   = !(move && out_v_q && !m_tready);

	assign s_tready = advance && (!busy_q || col_last);
	assign accept   = s_tvalid && s_tready;

	assign sy_full = $signed({2'b00, Y_ORIGIN}) - $signed({2'b00, in_w.pos_y_byte})
		+ $signed({6'b0, in_w.row});
	assign row_on  = (in_w.pos_y_byte != 8'd0) && (in_w.pos_y_byte != Y_HIDDEN)
		&& !sy_full[9] && (sy_full < $signed(10'(SCREEN_HEIGHT)));

	always_comb begin
		start  = 1'b0;
		pix_we = 1'b0;
		case (req)
			REQ_DRAW: begin
				start = accept && row_on;
			end
			REQ_LOAD_PIX: begin
				pix_we = accept && ({1'b0, in_w.load_addr} < 15'(PIX_DEPTH));
			end
			default: begin
				start  = 1'b0;
				pix_we = 1'b0;
			end
		endcase
	end

	assign sx_full = {1'b0, xb_q} + {5'b0, col_q};
	assign pix_idx = {code_q, row_q ^ {4{flipy_q}}, col_q ^ {4{flipx_q}}};

	srb_ram #(
		.WIDTH(4),
		.DEPTH(PIX_DEPTH)
	) u_pix_ram (
		.clk  (clk),
		.we   (pix_we),
		.waddr(in_w.load_addr[PIX_AW-1:0]),
		.wdata(in_w.load_data),
		.re   (advance),
		.raddr(pix_idx[PIX_AW-1:0]),
		.rdata(pix_rd)
	);

	srb_ram #(
		.WIDTH(1),
		.DEPTH(PEN_DEPTH)
	) u_pen_ram (
		.clk  (clk),
		.we   (advance && pwe_s1),
		.waddr(paddr_s1),
		.wdata(pdata_s1),
		.re   (advance),
		.raddr({color_s1, pix_rd}),
		.rdata(pen_transp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (advance && busy_q) begin
			if (col_last) begin
				busy_q <= 1'b0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xb_q    <= in_w.pos_x_byte;
			sy_q    <= sy_full[7:0];
			color_q <= in_w.attr_byte[3:0];
			code_q  <= code_mod_lut[in_w.code_byte[CODE_W-1:0]];
			row_q   <= in_w.row;
			flipx_q <= !in_w.attr_byte[6];
			flipy_q <= in_w.attr_byte[7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_v_s1 <= 1'b0;
			pwe_s1   <= 1'b0;
			col_v_s2 <= 1'b0;
		end else if (advance) begin
			col_v_s1 <= busy_q;
			pwe_s1   <= accept && (req == REQ_LOAD_PEN);
			col_v_s2 <= col_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vis_s1   <= (sx_full < 9'(SCREEN_WIDTH));
			end_s1   <= col_last;
			sx_s1    <= sx_full[7:0];
			sy_s1    <= sy_q;
			color_s1 <= color_q;
			paddr_s1 <= in_w.load_addr[7:0];
			pdata_s1 <= in_w.load_data[0];
			vis_s2   <= vis_s1;
			end_s2   <= end_s1;
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			pen_s2   <= {color_s1, pix_rd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q     <= 1'b0;
			pend_final_q <= 1'b0;
			out_v_q      <= 1'b0;
		end else if (advance) begin
			if (slot_emit) begin
				pend_v_q     <= 1'b1;
				pend_final_q <= end_s2;
			end else if (move) begin
				pend_v_q     <= 1'b0;
				pend_final_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (slot_emit) begin
				pend_x_q   <= sx_s2;
				pend_y_q   <= sy_s2;
				pend_pen_q <= pen_s2;
			end
			if (move) begin
				out_x_q    <= pend_x_q;
				out_y_q    <= pend_y_q;
				out_pen_q  <= pend_pen_q;
				out_last_q <= pend_final_q || !slot_emit;
			end
		end
	end

	assign out_w.pix_x = out_x_q;
	assign out_w.pix_y = out_y_q;
	assign out_w.pen   = out_pen_q;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_w;
	assign m_tlast  = out_last_q;

	a_end_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance && col_v_s1 && end_s1 |=> col_v_s2 && end_s2)
		else $error("Row end marker lost between pipeline stages.");

	a_seq_stops: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && col_last && advance && !start |=> !busy_q)
		else $error("Column sequencer kept running past the last column.");

	a_final_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_final_q |-> pend_v_q)
		else $error("Row end flag set on an empty held pixel.");

	a_pend_row_open: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q && !pend_final_q |-> col_v_s2)
		else $error("Held pixel waits on a row with no column behind it.");

	a_out_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, out_y_q} < 9'(SCREEN_HEIGHT)))
		else $error("Pixel write below the bottom screen line.");

endmodule
